// ===== src/assert_macros.svh =====
// Assertion macros shared by the compensation block's RTL.
// Needs clk and arst_n in the scope of every module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bpc_pkg.sv =====
// Shared types, constants and saturating helpers of the pressure/temperature compensation.
// No dependencies.
`default_nettype none

package bpc_pkg;

	localparam int unsigned CODE_W   = 24;
	localparam int unsigned SCALE_W  = 23;
	localparam int unsigned CFG_AW   = 6;
	localparam int unsigned CFG_DW   = 64;
	localparam int unsigned MUL_LAT  = 5;
	localparam int unsigned HPA_DIV  = 100;
	localparam int unsigned PQ_W     = 38;

	// divide by 100 as multiply by ceil(2^45 / 100) then shift by 45, exact below 2^38
	localparam int unsigned HPA_SH    = 45;
	localparam logic [63:0] HPA_RECIP = 64'd351843720889;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(524288);
	localparam logic [PQ_W-1:0]    PQ_CAP      = PQ_W'(HPA_DIV) << 31;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
	localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

	typedef enum logic [2:0] {
		REG_C0_C1   = 3'd0,
		REG_C00_C10 = 3'd1,
		REG_C01_C11 = 3'd2,
		REG_C20_C21 = 3'd3,
		REG_C30     = 3'd4,
		REG_SCALE   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] temp_code;
		logic [23:0] pressure_code;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temperature_q8;
		logic signed [31:0] pressure_hpa_q16;
	} out_t;

	typedef struct packed {
		logic signed [63:0] t;
		logic signed [63:0] p;
	} scaled_t;

	typedef struct packed {
		logic [23:0] c0_c1;
		logic [39:0] c00_c10;
		logic [31:0] c01_c11;
		logic [31:0] c20_c21;
		logic [15:0] c30;
	} coef_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_ctl_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] sum;
		sum = a + b;
		if (a[63] == b[63] && sum[63] != a[63]) begin
			return a[63] ? S64_MIN : S64_MAX;
		end
		return sum;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'(S32_MAX)) begin
			return S32_MAX;
		end
		if (v < 64'(S32_MIN)) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// No dependencies.
`default_nettype none

module bpc_div #(
	parameter int unsigned W  = 48,
	parameter int unsigned D  = 23,
	parameter int unsigned TW = 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  num,
	input  wire logic [D-1:0]  den,
	input  wire logic [TW-1:0] tag_in,
	output logic      [W-1:0]  quo,
	output logic      [TW-1:0] tag_out
);

	logic [W-1:0]  nq_s  [1:W];
	logic [D-1:0]  rem_s [1:W];
	logic [TW-1:0] tag_s [1:W];

	for (genvar i = 0; i < W; i++) begin : g_step
		logic [W-1:0]  nq_in;
		logic [D-1:0]  rem_in;
		logic [TW-1:0] tag_in_i;
		logic [D:0]    trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign nq_in    = num;
			assign rem_in   = '0;
			assign tag_in_i = tag_in;
		end else begin : g_rest
			assign nq_in    = nq_s[i];
			assign rem_in   = rem_s[i];
			assign tag_in_i = tag_s[i];
		end

		// bring down the next dividend bit and try the subtraction
		assign trial = {rem_in, nq_in[W-1]};
		assign ge    = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? D'(trial - {1'b0, den}) : D'(trial);
				nq_s[i+1]  <= {nq_in[W-2:0], ge};
				tag_s[i+1] <= tag_in_i;
			end
		end
	end

	assign quo     = nq_s[W];
	assign tag_out = tag_s[W];

endmodule

`default_nettype wire

// ===== src/bpc_mul.sv =====
// Pipelined 64x64 signed multiplier from 32x32 partial products, shift toward zero, saturate.
// Depends on bpc_pkg (saturation limits).
`default_nettype none

module bpc_mul #(
	parameter int unsigned SH = 0
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic signed      [63:0] y
);

	logic [63:0]  a_u, b_u;
	logic         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]  am_s1, bm_s1;
	logic [63:0]  ll_s2, lh_s2, hl_s2, hh_s2;
	logic [63:0]  ll_s3, hh_s3;
	logic [64:0]  mid_s3;
	logic [127:0] full_s4;
	logic [127:0] shd;
	logic signed [63:0] y_s5;

	assign a_u = a;
	assign b_u = b;
	assign shd = full_s4 >> SH;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= a[63] ^ b[63];
			am_s1   <= a[63] ? 64'(0) - a_u : a_u;
			bm_s1   <= b[63] ? 64'(0) - b_u : b_u;

			neg_s2  <= neg_s1;
			ll_s2   <= am_s1[31:0]  * bm_s1[31:0];
			lh_s2   <= am_s1[31:0]  * bm_s1[63:32];
			hl_s2   <= am_s1[63:32] * bm_s1[31:0];
			hh_s2   <= am_s1[63:32] * bm_s1[63:32];

			neg_s3  <= neg_s2;
			ll_s3   <= ll_s2;
			hh_s3   <= hh_s2;
			mid_s3  <= {1'b0, lh_s2} + {1'b0, hl_s2};

			neg_s4  <= neg_s3;
			full_s4 <= {hh_s3, ll_s3} + ({63'b0, mid_s3} << 32);

			if (neg_s4) begin
				if (shd[127:64] != '0 || shd[63:0] >= 64'(bpc_pkg::S64_MIN)) begin
					y_s5 <= bpc_pkg::S64_MIN;
				end else begin
					y_s5 <= 64'(0) - shd[63:0];
				end
			end else begin
				if (shd[127:64] != '0 || shd[63]) begin
					y_s5 <= bpc_pkg::S64_MAX;
				end else begin
					y_s5 <= shd[63:0];
				end
			end
		end
	end

	assign y = y_s5;

endmodule

`default_nettype wire

// ===== src/bpc_front.sv =====
// Front end: accepts raw codes and scales them to fixed point through two pipelined dividers.
// Depends on bpc_pkg and bpc_div.
`default_nettype none

module bpc_front #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire bpc_pkg::in_t                     in_data,
	input  wire logic [bpc_pkg::SCALE_W-1:0]      divisor,
	input  wire logic                             q_full,
	output logic                                  f_valid,
	output bpc_pkg::scaled_t                      f_data
);

	localparam int unsigned DW = bpc_pkg::CODE_W + FRAC_BITS;

	logic          en;
	logic [23:0]   t_mag, p_mag;
	logic [DW-1:0] t_quo, p_quo;
	logic          t_neg, p_neg;
	logic          v_s [1:DW+1];
	bpc_pkg::scaled_t res_q;

	// advance unless a finished item is blocked by a full queue
	assign en       = !v_s[DW+1] || !q_full;
	assign in_stall = !en;

	assign t_mag = in_data.temp_code[23]     ? 24'(0) - in_data.temp_code     : in_data.temp_code;
	assign p_mag = in_data.pressure_code[23] ? 24'(0) - in_data.pressure_code
		: in_data.pressure_code;

	bpc_div #(.W(DW), .D(bpc_pkg::SCALE_W), .TW(1)) u_t_div (
		.clk     (clk),
		.en      (en),
		.num     ({t_mag, {FRAC_BITS{1'b0}}}),
		.den     (divisor),
		.tag_in  (in_data.temp_code[23]),
		.quo     (t_quo),
		.tag_out (t_neg)
	);

	bpc_div #(.W(DW), .D(bpc_pkg::SCALE_W), .TW(1)) u_p_div (
		.clk     (clk),
		.en      (en),
		.num     ({p_mag, {FRAC_BITS{1'b0}}}),
		.den     (divisor),
		.tag_in  (in_data.pressure_code[23]),
		.quo     (p_quo),
		.tag_out (p_neg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DW + 1; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int i = 2; i <= DW + 1; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	// restore the sign of the truncated quotients
	always_ff @(posedge clk) begin
		if (en) begin
			res_q.t <= t_neg ? 64'(0) - 64'(t_quo) : 64'(t_quo);
			res_q.p <= p_neg ? 64'(0) - 64'(p_quo) : 64'(p_quo);
		end
	end

	assign f_valid = v_s[DW+1];
	assign f_data  = res_q;

endmodule

`default_nettype wire

// ===== src/bpc_back.sv =====
// Back end: temperature and pressure polynomials over shared-format fixed point.
// Depends on bpc_pkg and bpc_mul.
`default_nettype none

module bpc_back #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire bpc_pkg::scaled_t head,
	output logic                  pop,
	input  wire bpc_pkg::coef_t   coef,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output bpc_pkg::out_t         out_data
);

	localparam int unsigned ML    = bpc_pkg::MUL_LAT;
	localparam int unsigned S_A   = ML + 1;
	localparam int unsigned S_TQ  = S_A + 1;
	localparam int unsigned S_B   = S_A + ML + 1;
	localparam int unsigned S_C   = S_B + ML + 1;
	localparam int unsigned S_PR1 = S_C + 1;
	localparam int unsigned S_PR  = S_PR1 + 1;
	localparam int unsigned S_PM  = S_PR + 1;
	localparam int unsigned S_PQ  = S_PM + ML;
	localparam int unsigned S_OUT = S_PQ + 1;
	localparam int unsigned K_T   = FRAC_BITS - 8;
	localparam int unsigned K_P   = FRAC_BITS - 16;

	logic en;
	logic v_s [0:S_OUT];

	logic signed [11:0] c0, c1;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;
	logic signed [63:0] c0_half, c00_one, c10_one, c11_one, c20_one;

	logic signed [63:0] t_s0;
	logic signed [63:0] p_s   [0:S_B];
	logic signed [63:0] x_s   [S_A:S_C];
	logic signed [63:0] e_s   [S_B:S_PR1];
	logic signed [31:0] tq_s  [S_TQ:S_OUT-1];
	logic               pn_s  [S_PM:S_PQ];

	logic signed [63:0] tc1_m, pc30_m, pc21_m, tp_m, tc01_m, pa_m, de_m, pb_m;
	logic signed [63:0] temp_s6, a_s6, d_s6, tp_s6, b_s12, c_s18, pr1_s19, pr_s20;
	logic signed [63:0] temp_adj;
	logic [63:0]        pr_mag, pr_shd;
	logic [bpc_pkg::PQ_W-1:0] pm_s21;
	logic signed [63:0] pq_y;
	logic               pq_neg;
	logic [31:0]        pres;
	bpc_pkg::out_t      out_q;

	assign en  = !(v_s[S_OUT] && out_stall);
	assign pop = en && head_valid;

	// calibration fields, placed in the fixed-point format where the sums need it
	assign c0  = coef.c0_c1[23:12];
	assign c1  = coef.c0_c1[11:0];
	assign c00 = coef.c00_c10[39:20];
	assign c10 = coef.c00_c10[19:0];
	assign c01 = coef.c01_c11[31:16];
	assign c11 = coef.c01_c11[15:0];
	assign c20 = coef.c20_c21[31:16];
	assign c21 = coef.c20_c21[15:0];
	assign c30 = coef.c30;

	assign c0_half = 64'(c0)  <<< (FRAC_BITS - 1);
	assign c00_one = 64'(c00) <<< FRAC_BITS;
	assign c10_one = 64'(c10) <<< FRAC_BITS;
	assign c11_one = 64'(c11) <<< FRAC_BITS;
	assign c20_one = 64'(c20) <<< FRAC_BITS;

	bpc_mul #(.SH(0)) u_tc1 (.clk(clk), .en(en), .a(t_s0), .b(64'(c1)), .y(tc1_m));
	bpc_mul #(.SH(0)) u_pc30 (.clk(clk), .en(en), .a(p_s[0]), .b(64'(c30)), .y(pc30_m));
	bpc_mul #(.SH(0)) u_pc21 (.clk(clk), .en(en), .a(p_s[0]), .b(64'(c21)), .y(pc21_m));
	bpc_mul #(.SH(0)) u_tc01 (.clk(clk), .en(en), .a(t_s0), .b(64'(c01)), .y(tc01_m));
	bpc_mul #(.SH(FRAC_BITS)) u_tp (.clk(clk), .en(en), .a(t_s0), .b(p_s[0]), .y(tp_m));
	bpc_mul #(.SH(FRAC_BITS)) u_pa (.clk(clk), .en(en), .a(p_s[S_A]), .b(a_s6), .y(pa_m));
	bpc_mul #(.SH(FRAC_BITS)) u_de (.clk(clk), .en(en), .a(tp_s6), .b(d_s6), .y(de_m));
	bpc_mul #(.SH(FRAC_BITS)) u_pb (.clk(clk), .en(en), .a(p_s[S_B]), .b(b_s12), .y(pb_m));

	// truncate toward zero: bias negative values before the arithmetic shift
	assign temp_adj = temp_s6[63] ? temp_s6 + ((64'sd1 <<< K_T) - 64'sd1) : temp_s6;

	assign pr_mag = pr_s20[63] ? 64'(0) - 64'(pr_s20) : 64'(pr_s20);
	assign pr_shd = pr_mag >> K_P;

	// divide the clamped magnitude by 100 through the reciprocal
	bpc_mul #(.SH(bpc_pkg::HPA_SH)) u_hpa (
		.clk (clk),
		.en  (en),
		.a   (64'(pm_s21)),
		.b   (bpc_pkg::HPA_RECIP),
		.y   (pq_y)
	);

	assign pq_neg = pn_s[S_PQ];
	assign pres = pq_neg ? 32'(0) - pq_y[31:0]
		: (pq_y > 64'(bpc_pkg::S32_MAX) ? 32'(bpc_pkg::S32_MAX) : pq_y[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= S_OUT; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= head_valid;
			for (int i = 1; i <= S_OUT; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s0   <= head.t;
			p_s[0] <= head.p;
			for (int i = 1; i <= S_B; i++) begin
				p_s[i] <= p_s[i-1];
			end

			temp_s6 <= bpc_pkg::sat_add(c0_half, tc1_m);
			a_s6    <= bpc_pkg::sat_add(c20_one, pc30_m);
			d_s6    <= bpc_pkg::sat_add(c11_one, pc21_m);
			tp_s6   <= tp_m;

			x_s[S_A] <= tc01_m;
			for (int i = S_A + 1; i <= S_C; i++) begin
				x_s[i] <= x_s[i-1];
			end

			tq_s[S_TQ] <= bpc_pkg::sat32(temp_adj >>> K_T);
			for (int i = S_TQ + 1; i <= S_OUT - 1; i++) begin
				tq_s[i] <= tq_s[i-1];
			end

			b_s12    <= bpc_pkg::sat_add(c10_one, pa_m);
			e_s[S_B] <= de_m;
			for (int i = S_B + 1; i <= S_PR1; i++) begin
				e_s[i] <= e_s[i-1];
			end

			c_s18   <= bpc_pkg::sat_add(c00_one, pb_m);
			pr1_s19 <= bpc_pkg::sat_add(c_s18, x_s[S_C]);
			pr_s20  <= bpc_pkg::sat_add(pr1_s19, e_s[S_PR1]);

			// clamp the magnitude: anything past the cap saturates after the divide anyway
			pn_s[S_PM] <= pr_s20[63];
			for (int i = S_PM + 1; i <= S_PQ; i++) begin
				pn_s[i] <= pn_s[i-1];
			end
			pm_s21  <= (pr_shd > 64'(bpc_pkg::PQ_CAP)) ? bpc_pkg::PQ_CAP
				: pr_shd[bpc_pkg::PQ_W-1:0];

			out_q.temperature_q8   <= tq_s[S_OUT-1];
			out_q.pressure_hpa_q16 <= pres;
		end
	end

	assign out_valid = v_s[S_OUT];
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== src/baro_pressure_temp_compensation.sv =====
// Top level of the barometric compensation block: register file, queue, front and back.
// Depends on bpc_pkg, bpc_front, bpc_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Usage
// - Input channel in_valid/in_stall/in_data carries one raw temperature and one raw
//   pressure code per transfer; a transfer completes when in_valid is high and
//   in_stall is low.
// - Output channel out_valid/out_stall/out_data gives one compensated result per
//   input, in order.
// - Calibration and scale registers sit on the APB port at byte address 8*index,
//   64-bit data, pready tied high; write them only while the block is idle.
// - Throughput is one item per cycle while the receiver does not stall. On its way
//   to out_valid an input passes the two scaling dividers, which take one quotient
//   bit per stage; the queue, which adds one register; the pressure chain, which runs
//   three dependent multiplies of five stages each; and the divide by 100, a
//   five-stage reciprocal multiply.
// - When the receiver stalls, the back pipeline holds; the four-entry queue then
//   absorbs the front's output until it fills, after which in_stall rises.
// - Reset clears all valid bits and the queue, sets the coefficients to zero and the
//   scale to 524288; no clearing pass is needed.
module baro_pressure_temp_compensation #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire bpc_pkg::in_t                 in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output bpc_pkg::out_t                     out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bpc_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [bpc_pkg::CFG_DW-1:0]   pwdata,
	output logic [bpc_pkg::CFG_DW-1:0]        prdata,
	output logic                              pready
);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	bpc_pkg::coef_t             coef_q;
	logic [bpc_pkg::SCALE_W-1:0] scale_q;
	logic [bpc_pkg::SCALE_W-1:0] divisor;
	bpc_pkg::reg_idx_t          idx;
	logic                       wr_en;

	bpc_pkg::scaled_t f_data;
	logic             f_valid;
	bpc_pkg::q_ctl_t  q_ctl;
	bpc_pkg::scaled_t q_mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     fifo_cnt_q;
	logic             push, pop;

	assign pready = 1'b1;
	assign idx    = bpc_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel && penable && pwrite;

	// write the addressed register, dropping bits above its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= '0;
			scale_q <= bpc_pkg::SCALE_RESET;
		end else if (wr_en) begin
			case (idx)
				bpc_pkg::REG_C0_C1:   coef_q.c0_c1   <= pwdata[23:0];
				bpc_pkg::REG_C00_C10: coef_q.c00_c10 <= pwdata[39:0];
				bpc_pkg::REG_C01_C11: coef_q.c01_c11 <= pwdata[31:0];
				bpc_pkg::REG_C20_C21: coef_q.c20_c21 <= pwdata[31:0];
				bpc_pkg::REG_C30:     coef_q.c30     <= pwdata[15:0];
				bpc_pkg::REG_SCALE:   scale_q        <= pwdata[bpc_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bpc_pkg::REG_C0_C1:   prdata = 64'(coef_q.c0_c1);
			bpc_pkg::REG_C00_C10: prdata = 64'(coef_q.c00_c10);
			bpc_pkg::REG_C01_C11: prdata = 64'(coef_q.c01_c11);
			bpc_pkg::REG_C20_C21: prdata = 64'(coef_q.c20_c21);
			bpc_pkg::REG_C30:     prdata = 64'(coef_q.c30);
			bpc_pkg::REG_SCALE:   prdata = 64'(scale_q);
			default:              prdata = '0;
		endcase
	end

	// a zero scale divides by one
	assign divisor = (scale_q == '0) ? bpc_pkg::SCALE_W'(1) : scale_q;

	bpc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.divisor  (divisor),
		.q_full   (q_ctl.full),
		.f_valid  (f_valid),
		.f_data   (f_data)
	);

	// queue between front and back: push finished scalings, pop into the back pipeline
	assign q_ctl.full  = (fifo_cnt_q == (QAW+1)'(QDEPTH));
	assign q_ctl.valid = (fifo_cnt_q != '0);
	assign push        = f_valid && !q_ctl.full;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= f_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	bpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_ctl.valid),
		.head       (q_mem_q[rd_ptr_q]),
		.pop        (pop),
		.coef       (coef_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	`ASSERT_HOLDS(a_q_bound, fifo_cnt_q <= (QAW+1)'(QDEPTH), "queue count past depth")
	`ASSERT_NEXT(a_q_grow, push && !pop, fifo_cnt_q == $past(fifo_cnt_q) + 1'b1, "queue count lost a push")
	`ASSERT_IMPLIES(a_q_empty_pop, fifo_cnt_q == '0, !pop, "pop from empty queue")

endmodule

`default_nettype wire
